FILE: hw/rtl/crcd_pkg.sv
// package: words, command codes and controller states of the clock replacement directory
`default_nettype none

package crcd_pkg;

    localparam int CmdBits  = 1;
    localparam int KeyBits  = 32;
    localparam int SlotBits = 3;

    localparam logic [CmdBits-1:0] CMD_LOOKUP = 1'b0;
    localparam logic [CmdBits-1:0] CMD_INSERT = 1'b1;

    typedef struct packed {
        logic [CmdBits-1:0] command;
        logic [KeyBits-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic                hit;
        logic [SlotBits-1:0] slot;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/crcd_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module crcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/clock_replacement_cache_directory.sv
// top level: directory of a fully associative cache with clock (second-chance) replacement
//
// input channel i_in_valid / o_in_stall carries a word {command, key}; output
// channel o_out_valid / i_out_stall carries a word {hit, slot}. a word moves
// at a rising edge where valid is high and stall is low.
// one request is worked at a time; o_in_stall is high from acceptance until
// the result is handed to the output register.
// lookup: the key ram is read one entry per cycle from entry 0 and each read
// is compared in the cycle after; the first hit or the compare of the last
// entry ends the lookup.
// insert: the hand steps one entry per cycle over the used bits, clearing
// them, and writes the key ram at the first clear one.
// the next request may be taken in the cycle after a result is loaded.
// the output register holds a finished result while the receiver stalls and
// a new request is taken meanwhile; the next result waits until it drains.
// reset clears all valid and used bits, the hand and the output valid; the
// key ram is not cleared, empty entries are masked by their valid bits.
`default_nettype none

module clock_replacement_cache_directory
    import crcd_pkg::*;
#(
    parameter int ENTRIES  = 8,
    parameter int KEY_BITS = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    t_state r_state;
    t_state n_state;

    logic [KEY_BITS-1:0] w_key_in;
    logic [KEY_BITS-1:0] r_key;
    logic [ENTRIES-1:0]  r_valid;
    logic [ENTRIES-1:0]  r_used;
    logic [IW-1:0]       r_hand;
    logic [IW-1:0]       r_addr;
    logic                r_addr_live;
    logic [IW-1:0]       r_cmp_idx;
    logic                r_cmp_live;
    t_out_word           r_res;
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic                w_accept;
    logic [KEY_BITS-1:0] w_rdata;
    logic                w_hit_now;
    logic                w_last_cmp;
    logic                w_used_here;
    logic                w_we;
    logic                w_out_load;

    generate
        if (KEY_BITS > KeyBits) begin : g_key_wide
            assign w_key_in = {{(KEY_BITS - KeyBits){1'b0}}, i_in_word.key};
        end else if (KEY_BITS == KeyBits) begin : g_key_same
            assign w_key_in = i_in_word.key;
        end else begin : g_key_narrow
            assign w_key_in = i_in_word.key[KEY_BITS-1:0];
        end
    endgenerate

    crcd_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_hand),
        .i_wdata (r_key),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_hit_now   = r_cmp_live && r_valid[r_cmp_idx] && (w_rdata == r_key);
    assign w_last_cmp  = r_cmp_live && (r_cmp_idx == LAST);
    assign w_used_here = r_used[r_hand];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_word.command == CMD_INSERT) ? S_SWEEP : S_LOOK;
                end
            end
            S_LOOK: begin
                if (w_hit_now || w_last_cmp) begin
                    n_state = S_DONE;
                end
            end
            S_SWEEP: begin
                if (!w_used_here) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_we       = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_LOOK:  ;
            S_SWEEP: w_we = !w_used_here;
            S_DONE:  w_out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_used      <= '0;
            r_hand      <= '0;
            r_addr      <= '0;
            r_addr_live <= 1'b0;
            r_cmp_idx   <= '0;
            r_cmp_live  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_addr      <= '0;
                r_addr_live <= 1'b1;
                r_cmp_live  <= 1'b0;
            end
            if (r_state == S_LOOK) begin
                r_cmp_idx  <= r_addr;
                r_cmp_live <= r_addr_live;
                if (r_addr == LAST) begin
                    r_addr_live <= 1'b0;
                end else begin
                    r_addr <= IW'(r_addr + 1'b1);
                end
                if (w_hit_now) begin
                    r_used[r_cmp_idx] <= 1'b1;
                end
            end
            if (r_state == S_SWEEP) begin
                if (w_used_here) begin
                    r_used[r_hand] <= 1'b0;
                    r_hand         <= (r_hand == LAST) ? '0 : IW'(r_hand + 1'b1);
                end else begin
                    r_used[r_hand]  <= 1'b1;
                    r_valid[r_hand] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= w_key_in;
        end
        if (r_state == S_LOOK) begin
            if (w_hit_now) begin
                r_res.hit  <= 1'b1;
                r_res.slot <= SlotBits'(r_cmp_idx);
            end else begin
                r_res.hit  <= 1'b0;
                r_res.slot <= '0;
            end
        end
        if (w_we) begin
            r_res.hit  <= 1'b0;
            r_res.slot <= SlotBits'(r_hand);
        end
        if (w_out_load) begin
            r_out_word <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("request accepted while another is in flight");

    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hand <= LAST)
        else $error("clock hand beyond last entry");

    a_write_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_used[$past(r_hand)] && r_valid[$past(r_hand)] && r_state == S_DONE))
        else $error("insert did not mark its entry");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> o_out_valid)
        else $error("finished result not presented");

    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && r_cmp_live) |-> r_cmp_idx <= LAST)
        else $error("lookup compare index out of range");

endmodule

`default_nettype wire

FILE: test/tb_clock_dir_pkg.sv
// scoreboard class: shadow copy of the clock replacement directory and its predicted words
package tb_clock_dir_pkg;
    import crcd_pkg::*;

    localparam int DirSlots = 8;

    class clock_dir_shadow;
        logic [KeyBits-1:0]  keys [DirSlots];
        bit                  valid [DirSlots];
        bit                  used [DirSlots];
        logic [SlotBits-1:0] hand;
        t_out_word           pending_results [$];
        int unsigned         n_lookup;
        int unsigned         n_hit;
        int unsigned         n_insert;
        int unsigned         n_wrap;
        int unsigned         n_checked;
        int unsigned         n_errors;

        function void clear();
            for (int i = 0; i < DirSlots; i++) begin
                keys[i]  = '0;
                valid[i] = 1'b0;
                used[i]  = 1'b0;
            end
            hand = '0;
            pending_results.delete();
            n_lookup  = 0;
            n_hit     = 0;
            n_insert  = 0;
            n_wrap    = 0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function void report(string what, t_out_word want, t_out_word got);
            n_errors++;
            if (n_errors <= 10)
                $display("mismatch: %s, expected hit=%0d slot=%0d, got hit=%0d slot=%0d",
                         what, want.hit, want.slot, got.hit, got.slot);
        endfunction

        // note an accepted request word and predict its result word
        function void take_request(t_in_word w);
            t_out_word   res;
            bit          found;
            int unsigned steps;
            res   = '0;
            found = 1'b0;
            steps = 0;
            if (w.command == CMD_LOOKUP) begin
                n_lookup++;
                for (int i = 0; i < DirSlots; i++) begin
                    if (!found && valid[i] && keys[i] == w.key) begin
                        found    = 1'b1;
                        used[i]  = 1'b1;
                        res.hit  = 1'b1;
                        res.slot = SlotBits'(i);
                    end
                end
                if (found)
                    n_hit++;
            end else begin
                n_insert++;
                while (used[hand]) begin
                    used[hand] = 1'b0;
                    hand = SlotBits'((int'(hand) + 1) % DirSlots);
                    steps++;
                end
                if (steps == DirSlots)
                    n_wrap++;
                keys[hand]  = w.key;
                valid[hand] = 1'b1;
                used[hand]  = 1'b1;
                res.slot    = hand;
            end
            pending_results.push_back(res);
        endfunction

        // compare a result word with the oldest prediction
        function void match_result(t_out_word got);
            t_out_word want;
            if (pending_results.size() == 0) begin
                report("word with nothing expected", '0, got);
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (got.hit !== want.hit || got.slot !== want.slot)
                report("wrong word", want, got);
        endfunction

        function void flag_leftovers();
            while (pending_results.size() != 0)
                report("word never arrived", pending_results.pop_front(), '0);
        endfunction
    endclass

endpackage

FILE: test/tb_top.sv
// testbench top: drives lookups and inserts into the clock replacement directory and checks results
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crcd_pkg::*;
    import tb_clock_dir_pkg::*;

    localparam int RandomWords = 500;
    localparam int RunLimit    = 400000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    clock_dir_shadow     shadow;
    logic [KeyBits-1:0]  key_pool [$];
    bit                  calm = 1'b0;
    int unsigned         stall_left = 0;
    int unsigned         open_left = 0;
    int unsigned         cycle_count = 0;

    clock_replacement_cache_directory #(
        .ENTRIES  (DirSlots),
        .KEY_BITS (KeyBits)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RunLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            shadow.match_result(o_out_word);
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (calm) begin
            i_out_stall = 1'b0;
            stall_left  = 0;
        end else if (stall_left > 0) begin
            i_out_stall = 1'b1;
            stall_left--;
        end else begin
            i_out_stall = 1'b0;
            if (open_left > 0) begin
                open_left--;
            end else begin
                stall_left = idle_len();
                open_left  = $urandom_range(0, 6);
            end
        end
    end

    function automatic t_in_word mk(input logic [CmdBits-1:0] c, input logic [KeyBits-1:0] k);
        t_in_word w;
        w.command = c;
        w.key     = k;
        return w;
    endfunction

    function automatic logic [KeyBits-1:0] edge_key();
        logic [KeyBits-1:0] one_bit;
        one_bit = '0;
        one_bit[$urandom_range(0, KeyBits - 1)] = 1'b1;
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return one_bit;
            default: return ~one_bit;
        endcase
    endfunction

    function automatic t_in_word random_word();
        int unsigned        r;
        logic [KeyBits-1:0] k;
        r = $urandom_range(0, 99);
        if (key_pool.size() != 0 && r < 70)
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (r < 90)
            k = $urandom;
        else
            k = edge_key();
        if ($urandom_range(0, 99) < 35) begin
            // inserts mostly bring new keys, sometimes a duplicate
            if ($urandom_range(0, 99) < 75)
                k = $urandom;
            key_pool.push_back(k);
            if (key_pool.size() > 12)
                void'(key_pool.pop_front());
            return mk(CMD_INSERT, k);
        end
        return mk(CMD_LOOKUP, k);
    endfunction

    task automatic send_word(input t_in_word w);
        int unsigned gap;
        gap = calm ? 0 : idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = w;
        do @(posedge i_clk); while (o_in_stall);
        shadow.take_request(w);
    endtask

    task automatic wait_all_returned();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (shadow.pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_word(mk(CMD_LOOKUP, 32'h0000_0000));
        send_word(mk(CMD_LOOKUP, 32'hffff_ffff));
        send_word(mk(CMD_INSERT, 32'h0000_0000));
        send_word(mk(CMD_INSERT, 32'hffff_ffff));
        send_word(mk(CMD_LOOKUP, 32'hffff_ffff));
        send_word(mk(CMD_LOOKUP, 32'h0000_0000));
        // duplicate key, lookup reports the lowest slot
        send_word(mk(CMD_INSERT, 32'h0000_0000));
        send_word(mk(CMD_LOOKUP, 32'h0000_0000));
        send_word(mk(CMD_INSERT, 32'ha5a5_a5a5));
        send_word(mk(CMD_INSERT, 32'h5a5a_5a5a));
        send_word(mk(CMD_INSERT, 32'h8000_0000));
        send_word(mk(CMD_INSERT, 32'h0000_0001));
        send_word(mk(CMD_INSERT, 32'h1234_5678));
        send_word(mk(CMD_LOOKUP, 32'h1234_5678));
        // the hand clears the used bits of slots 7 and 0, wrapping round, and writes slot 1
        send_word(mk(CMD_INSERT, 32'hdead_beef));
        send_word(mk(CMD_LOOKUP, 32'h8000_0000));
        send_word(mk(CMD_LOOKUP, 32'h5a5a_5a5a));
        send_word(mk(CMD_INSERT, 32'hcafe_f00d));
        send_word(mk(CMD_LOOKUP, 32'hdead_beef));
        send_word(mk(CMD_LOOKUP, 32'h0000_0002));
        send_word(mk(CMD_LOOKUP, 32'h7fff_ffff));
        send_word(mk(CMD_INSERT, 32'h7fff_ffff));
        send_word(mk(CMD_LOOKUP, 32'h7fff_ffff));
        wait_all_returned();
    endtask

    initial begin
        shadow = new();
        shadow.clear();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        for (int n = 0; n < RandomWords; n++) begin
            calm = ((n / 60) % 4) == 2;
            if (n == RandomWords / 2)
                wait_all_returned();
            send_word(random_word());
        end
        calm = 1'b0;
        wait_all_returned();
        repeat (DirSlots + 8) @(posedge i_clk);
        shadow.flag_leftovers();

        $display("run covered %0d lookups (%0d hits) and %0d inserts, %0d of them full sweeps",
                 shadow.n_lookup, shadow.n_hit, shadow.n_insert, shadow.n_wrap);
        $display("%0d result words checked, %0d errors", shadow.n_checked, shadow.n_errors);
        if (shadow.n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/crcd_pkg.sv
hw/rtl/crcd_ram.sv
hw/rtl/clock_replacement_cache_directory.sv
test/tb_clock_dir_pkg.sv
test/tb_top.sv
